@@ design/ordered_list_deque_with_search_assert.svh @@
// Assertion macros used by the ordered list deque datapath.
`ifndef ORDERED_LIST_DEQUE_WITH_SEARCH_ASSERT_SVH
`define ORDERED_LIST_DEQUE_WITH_SEARCH_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define OLDQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define OLDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/oldq_pkg.sv @@
// Shared types and codes for the ordered list deque.
`default_nettype none

package oldq_pkg;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_DELETE     = 3'd4;
  localparam mode_t MODE_SEARCH     = 3'd5;
  localparam mode_t MODE_CLEAR      = 3'd6;

  typedef logic [1:0] status_t;
  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_RD_FRONT,
    S_RD_BACK,
    S_CAP_BACK,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic shift;
    logic rd_front;
    logic rd_back;
    logic cap_back;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_scan;
    logic is_delete;
    logic match;
    logic scan_end;
    logic shift_end;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/oldq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module oldq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/oldq_ctrl.sv @@
// Controller state machine for the ordered list deque.
`default_nettype none

module oldq_ctrl import oldq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_EXEC;
      S_EXEC:     state_nxt = stat.is_scan ? S_SCAN : S_RD_FRONT;
      S_SCAN: begin
        if (stat.match) begin
          state_nxt = stat.is_delete ? S_SHIFT : S_RD_FRONT;
        end else if (stat.scan_end) begin
          state_nxt = S_RD_FRONT;
        end
      end
      S_SHIFT:    if (stat.shift_end) state_nxt = S_RD_FRONT;
      S_RD_FRONT: state_nxt = S_RD_BACK;
      S_RD_BACK:  state_nxt = S_CAP_BACK;
      S_CAP_BACK: state_nxt = S_LOAD;
      S_LOAD:     if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE:     cmd.accept   = in_valid;
      S_EXEC:     cmd.exec     = 1'b1;
      S_SCAN:     cmd.scan     = 1'b1;
      S_SHIFT:    cmd.shift    = 1'b1;
      S_RD_FRONT: cmd.rd_front = 1'b1;
      S_RD_BACK:  cmd.rd_back  = 1'b1;
      S_CAP_BACK: cmd.cap_back = 1'b1;
      S_LOAD:     cmd.load_out = stat.out_free;
      default:    cmd          = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/oldq_dp.sv @@
// Datapath of the ordered list deque: circular entry store, pointers and result register.
`default_nettype none

`include "ordered_list_deque_with_search_assert.svh"

module oldq_dp import oldq_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic        [2:0]  in_mode,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [1:0]  out_status,
  output logic                    out_found,
  output logic           [CW-1:0] out_entry_count,
  output logic                    out_is_empty,
  output logic signed      [31:0] out_front_value,
  output logic signed      [31:0] out_back_value
);

  // Map a list position to a store address: head plus position, wrapped once.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(pos);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  // Sign-extend a stored value to the 32-bit result field.
  function automatic logic [31:0] report(input logic [VALUE_BITS-1:0] x);
    logic [VALUE_BITS+31:0] ext;
    ext = {{32{x[VALUE_BITS-1]}}, x};
    return ext[31:0];
  endfunction

  mode_t                 mode_r, mode_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0] front_r, front_nxt;
  logic [VALUE_BITS-1:0] back_r, back_nxt;
  status_t               status_r, status_nxt;
  logic                  found_r, found_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         ridx_r, ridx_nxt;
  logic [CW-1:0]         cidx_r, cidx_nxt;
  logic                  cvalid_r, cvalid_nxt;
  logic [CW-1:0]         sidx_r, sidx_nxt;
  logic [CW-1:0]         wpos_r, wpos_nxt;
  logic                  wvalid_r, wvalid_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic                  out_found_r;
  logic [CW-1:0]         out_count_r;
  logic                  out_empty_r;
  logic [31:0]           out_front_r;
  logic [31:0]           out_back_r;

  logic [VALUE_BITS+31:0] in_wide;
  logic [VALUE_BITS-1:0]  rdata;
  logic [VALUE_BITS-1:0]  wdata;
  logic                   ram_we;
  logic                   wr_front;
  logic [CW-1:0]          rd_idx;
  logic [CW-1:0]          wr_idx;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          head_dec;
  logic [AW-1:0]          head_inc;
  logic                   is_full;
  logic                   is_zero;

  assign in_wide  = {{VALUE_BITS{1'b0}}, in_value};
  assign head_dec = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + AW'(1);
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_zero  = (count_r == '0);

  always_comb begin
    stat.is_scan   = (mode_r == MODE_DELETE) || (mode_r == MODE_SEARCH);
    stat.is_delete = (mode_r == MODE_DELETE);
    stat.match     = cvalid_r && (rdata == key_r);
    stat.scan_end  = (ridx_r == count_r) && !cvalid_r;
    stat.shift_end = (sidx_r == count_r) && !wvalid_r;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    ridx_nxt   = ridx_r;
    cidx_nxt   = cidx_r;
    cvalid_nxt = cvalid_r;
    sidx_nxt   = sidx_r;
    wpos_nxt   = wpos_r;
    wvalid_nxt = wvalid_r;
    ram_we     = 1'b0;
    wr_front   = 1'b0;
    wr_idx     = wpos_r;
    wdata      = key_r;
    rd_idx     = ridx_r;

    if (cmd.accept) begin
      mode_nxt   = in_mode;
      key_nxt    = in_wide[VALUE_BITS-1:0];
      status_nxt = STAT_DONE;
      found_nxt  = 1'b0;
    end

    if (cmd.exec) begin
      unique case (mode_r) inside
        MODE_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = STAT_FULL;
          end else begin
            head_nxt  = head_dec;
            ram_we    = 1'b1;
            wr_front  = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        MODE_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            wr_idx    = count_r;
            count_nxt = count_r + CW'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (is_zero) begin
            status_nxt = STAT_EMPTY;
          end else begin
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
          end
        end
        MODE_POP_BACK: begin
          if (is_zero) begin
            status_nxt = STAT_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        MODE_DELETE, MODE_SEARCH: begin
          ridx_nxt   = '0;
          cvalid_nxt = 1'b0;
        end
        MODE_CLEAR: count_nxt = '0;
        default: ;
      endcase
    end

    // Scan: issue one read per cycle, compare the data returned in the next cycle.
    if (cmd.scan) begin
      if (ridx_r != count_r) begin
        rd_idx     = ridx_r;
        ridx_nxt   = ridx_r + CW'(1);
        cidx_nxt   = ridx_r;
        cvalid_nxt = 1'b1;
      end else begin
        cvalid_nxt = 1'b0;
      end
      if (stat.match) begin
        found_nxt  = 1'b1;
        sidx_nxt   = cidx_r + CW'(1);
        wpos_nxt   = cidx_r;
        wvalid_nxt = 1'b0;
        cvalid_nxt = 1'b0;
      end
    end

    // Shift: read the entry above, write it one place down on the next cycle.
    if (cmd.shift) begin
      if (sidx_r != count_r) begin
        rd_idx     = sidx_r;
        sidx_nxt   = sidx_r + CW'(1);
        wvalid_nxt = 1'b1;
      end else begin
        wvalid_nxt = 1'b0;
      end
      if (wvalid_r) begin
        ram_we   = 1'b1;
        wr_idx   = wpos_r;
        wdata    = rdata;
        wpos_nxt = wpos_r + CW'(1);
      end
      if (stat.shift_end) begin
        count_nxt = count_r - CW'(1);
      end
    end

    if (cmd.rd_front) begin
      rd_idx = '0;
    end
    if (cmd.rd_back) begin
      front_nxt = rdata;
      rd_idx    = is_zero ? '0 : count_r - CW'(1);
    end
    if (cmd.cap_back) begin
      back_nxt = rdata;
    end
  end

  assign raddr = phys(head_r, rd_idx);
  assign waddr = wr_front ? head_dec : phys(head_r, wr_idx);

  oldq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      cvalid_r    <= 1'b0;
      wvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cvalid_r    <= cvalid_nxt;
      wvalid_r    <= wvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    front_r  <= front_nxt;
    back_r   <= back_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    ridx_r   <= ridx_nxt;
    cidx_r   <= cidx_nxt;
    sidx_r   <= sidx_nxt;
    wpos_r   <= wpos_nxt;
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_count_r  <= count_r;
      out_empty_r  <= is_zero;
      out_front_r  <= is_zero ? '0 : report(front_r);
      out_back_r   <= is_zero ? '0 : report(back_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_front_value = $signed(out_front_r);
  assign out_back_value  = $signed(out_back_r);

  `OLDQ_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "entry count above capacity")
  `OLDQ_ASSERT_IMP(a_shift_in_range, cmd.shift && ram_we, wpos_r < count_r, "shift write past last entry")
  `OLDQ_ASSERT_IMP(a_empty_flag, out_valid_r, out_empty_r == (out_count_r == '0), "empty flag disagrees with count")
  `OLDQ_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_r || !out_stall, "result overwritten before transfer")

endmodule

`default_nettype wire

@@ design/ordered_list_deque_with_search.sv @@
// Top level of the ordered list deque with search and delete.
//
// Usage: one input transfer carries a mode (push front, push back, pop front,
// pop back, delete value, search value, clear) and a value. Each input transfer
// yields exactly one output transfer describing the list after the operation:
// status, found flag, entry count, empty flag, front and back values.
//
// Sequencing: the block works on one item at a time. Push, pop, clear and
// unused modes go from the input transfer through execute, front fetch, back
// fetch and capture to loading the result. A search reads entries in order
// until a hit or the end of the list; a delete that hits then moves the later
// entries down one place. The next item is taken in the cycle after the result
// is loaded. Every scan step, shift step and front/back fetch uses the single
// read port of the entry store once.
//
// A result waits in an output register; the next item is accepted while it is
// held. If the receiver keeps stalling, the following item completes and then
// waits for the output register to drain before its own result is loaded.
//
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. Stored entries are not cleared; only entries below the count are used.
`default_nettype none

module ordered_list_deque_with_search import oldq_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [2:0]  in_mode,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [1:0]  out_status,
  output logic                    out_found,
  output logic           [CW-1:0] out_entry_count,
  output logic                    out_is_empty,
  output logic signed      [31:0] out_front_value,
  output logic signed      [31:0] out_back_value
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each operation: accept, execute, scan/shift, fetch ends, load result.
  oldq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the entries, pointers and the output register.
  oldq_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value)
  );

endmodule

`default_nettype wire
